FILE: rtl/core/htplp_pkg.sv
// Shared types, constants and lookup functions for the header token list parser.
// Used by htplp_front, htplp_back and http_token_param_list_parser_top; no dependencies.
package htplp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned OCTET_W = 8;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned CODE_W  = 3;

  // Character classes.
  localparam logic [CLASS_W-1:0] CLS_INVALID = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_END     = 4'd9;

  // Parser states with a fixed meaning.
  localparam logic [STATE_W-1:0] ST_ERROR     = 4'd0;
  localparam logic [STATE_W-1:0] ST_START_REQ = 4'd1;
  localparam logic [STATE_W-1:0] ST_START_OPT = 4'd12;
  localparam logic [STATE_W-1:0] ST_MATCH     = 4'd13;

  // Event codes.
  localparam logic [CODE_W-1:0] EV_NONE       = 3'd0;
  localparam logic [CODE_W-1:0] EV_TOKEN_BYTE = 3'd1;
  localparam logic [CODE_W-1:0] EV_NAME_BYTE  = 3'd2;
  localparam logic [CODE_W-1:0] EV_VALUE_BYTE = 3'd3;
  localparam logic [CODE_W-1:0] EV_PARAM_DONE = 3'd4;
  localparam logic [CODE_W-1:0] EV_ELEM_DONE  = 3'd5;
  localparam logic [CODE_W-1:0] EV_BOTH_DONE  = 3'd6;

  // One classified request waiting between the front and the back.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [OCTET_W-1:0] octet;
    logic               end_mark;
  } q_item_t;

  // Packed class table: eight nibbles per word, lowest octet in the top nibble.
  localparam logic [31:0] CLASS_ROM [16] = '{
    32'h00000000, 32'h03000000, 32'h00000000, 32'h00000000,
    32'h32822222, 32'h11226221, 32'h22222222, 32'h22141511,
    32'h12222222, 32'h22222222, 32'h22222222, 32'h22217122,
    32'h22222222, 32'h22222222, 32'h22222222, 32'h22212120
  };

  // Transition table: high nibble is the event code, low nibble the next state.
  localparam logic [7:0] TRANS_ROM [16][10] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h12, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h12, 8'h03, 8'h04, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h5d},
    '{8'h00, 8'h00, 8'h00, 8'h03, 8'h04, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h5d},
    '{8'h00, 8'h00, 8'h25, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h25, 8'h06, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h38, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0a, 8'h00},
    '{8'h00, 8'h00, 8'h38, 8'h4b, 8'h44, 8'h00, 8'h6c, 8'h00, 8'h00, 8'h6d},
    '{8'h00, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h00},
    '{8'h00, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h3a, 8'h09, 8'h4b, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h0b, 8'h04, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h5d},
    '{8'h00, 8'h00, 8'h12, 8'h0c, 8'h00, 8'h00, 8'h0c, 8'h00, 8'h00, 8'h0d},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Octets with the top bit set are never valid.
  function automatic logic [CLASS_W-1:0] class_of(input logic [OCTET_W-1:0] b);
    logic [31:0] word;
    begin
      word = CLASS_ROM[b[6:3]];
      if (b[7]) begin
        class_of = CLS_INVALID;
      end else begin
        class_of = word[{~b[2:0], 2'b00} +: CLASS_W];
      end
    end
  endfunction

  function automatic logic [7:0] trans_of(input logic [STATE_W-1:0] st,
                                          input logic [CLASS_W-1:0] cls);
    begin
      if (cls > CLS_END) begin
        trans_of = 8'h00;
      end else begin
        trans_of = TRANS_ROM[st][cls];
      end
    end
  endfunction

endpackage

FILE: rtl/core/http_token_param_list_parser_top.sv
// Header token list parser: one octet request in, one event request out.
// An accepted octet is first written into the queue; the back then pops it and registers
// its event in the output register, from which it is taken when out_tready is high.
// Throughput is one request per cycle unless the output stalls; the table lookup is combinational.
// A queue of QUEUE_DEPTH requests decouples the input from the output register.
// Synchronous active-low reset empties the queue and output, sets require_element and
// restarts the parser; no clearing pass is needed.
module http_token_param_list_parser_top #(
  parameter int unsigned QUEUE_DEPTH = htplp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: bit 0 is require_element.
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // Input stream. tdata: [7:0] octet. tlast: end_mark.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // Output stream. tdata: [7:0] event_byte, [8] rejected, [9] accepted, rest zero.
  // tuser: [2:0] event_code.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [2:0]  out_tuser
);

  // The front classifies each octet through the class table, or gives it the end class when
  // the end mark is set, as the request is accepted, so the back sees only the class, the octet and the end mark.
  htplp_pkg::q_item_t          q_item;
  logic                        q_valid;
  logic                        q_pop;
  logic [htplp_pkg::OCTET_W-1:0] event_byte;
  logic                        rejected;
  logic                        accepted;

  htplp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .octet    (in_tdata),
    .end_mark (in_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // The back holds the parser state and the sticky error flag, and pops a
  // request whenever its output register is empty or being drained.
  htplp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .event_code  (out_tuser),
    .event_byte  (event_byte),
    .rejected    (rejected),
    .accepted    (accepted)
  );

  assign out_tdata = {6'b0, accepted, rejected, event_byte};

  // An accepted list can never also carry the error flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> !out_tdata[8])
    else $error("accepted list reported as rejected");

  // Acceptance comes with the closing element event, or with no event at all when the
  // list was empty or ended after a separator.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |->
      (out_tuser == htplp_pkg::EV_NONE || out_tuser == htplp_pkg::EV_ELEM_DONE ||
       out_tuser == htplp_pkg::EV_BOTH_DONE))
    else $error("acceptance with an unexpected event");

  // Only byte events carry a data byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == htplp_pkg::EV_NONE || out_tuser == htplp_pkg::EV_PARAM_DONE ||
                   out_tuser == htplp_pkg::EV_ELEM_DONE || out_tuser == htplp_pkg::EV_BOTH_DONE)
      |-> out_tdata[7:0] == 8'h00)
    else $error("non-byte event carries a data byte");

endmodule

FILE: rtl/core/htplp_front.sv
// Front part of the header token list parser: classifies each input request
// and holds it in a short queue for the back part. Depends on htplp_pkg.
module htplp_front #(
  parameter int unsigned QUEUE_DEPTH = htplp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [htplp_pkg::OCTET_W-1:0] octet,
  input  logic                          end_mark,
  output logic                          q_valid,
  input  logic                          q_pop,
  output htplp_pkg::q_item_t            q_item
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  htplp_pkg::q_item_t entry_r [QUEUE_DEPTH];
  htplp_pkg::q_item_t item_nxt;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;

  always_comb begin
    item_nxt.octet    = octet;
    item_nxt.end_mark = end_mark;
    item_nxt.cls      = end_mark ? htplp_pkg::CLS_END : htplp_pkg::class_of(octet);
  end

  assign in_ready = (count_r != FULL_CNT);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/htplp_back.sv
// Back part of the header token list parser: runs the table-driven state
// machine on queued requests and holds the result register. Depends on htplp_pkg.
module htplp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  htplp_pkg::q_item_t            q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [htplp_pkg::CODE_W-1:0]  event_code,
  output logic [htplp_pkg::OCTET_W-1:0] event_byte,
  output logic                          rejected,
  output logic                          accepted
);

  logic                           require_r;
  logic [htplp_pkg::STATE_W-1:0]  state_r, state_nxt;
  logic                           err_r, err_nxt;
  logic                           out_valid_r;
  logic [htplp_pkg::CODE_W-1:0]   code_r, code_nxt;
  logic [htplp_pkg::OCTET_W-1:0]  byte_r, byte_nxt;
  logic                           rej_r, rej_nxt;
  logic                           acc_r, acc_nxt;
  logic [7:0]                     entry;
  logic [htplp_pkg::STATE_W-1:0]  tgt;
  logic [htplp_pkg::CODE_W-1:0]   act;
  logic [htplp_pkg::STATE_W-1:0]  start_st;

  assign q_pop    = q_valid && (!out_valid_r || out_ready);
  assign start_st = require_r ? htplp_pkg::ST_START_REQ : htplp_pkg::ST_START_OPT;
  assign entry    = htplp_pkg::trans_of(state_r, q_item.cls);
  assign tgt      = entry[3:0];
  assign act      = entry[6:4];

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    code_nxt  = htplp_pkg::EV_NONE;
    byte_nxt  = '0;
    acc_nxt   = 1'b0;
    if (!err_r) begin
      if (q_item.cls == htplp_pkg::CLS_INVALID || tgt == htplp_pkg::ST_ERROR) begin
        err_nxt   = 1'b1;
        state_nxt = htplp_pkg::ST_ERROR;
      end else begin
        code_nxt  = act;
        state_nxt = tgt;
        if (act == htplp_pkg::EV_TOKEN_BYTE || act == htplp_pkg::EV_VALUE_BYTE) begin
          byte_nxt = q_item.octet;
        end else if (act == htplp_pkg::EV_NAME_BYTE) begin
          // ASCII upper case folds to lower case in parameter names.
          byte_nxt = q_item.octet;
          if (q_item.octet >= 8'h41 && q_item.octet <= 8'h5a) begin
            byte_nxt = q_item.octet | 8'h20;
          end
        end
        acc_nxt = q_item.end_mark && (tgt == htplp_pkg::ST_MATCH);
      end
    end
    rej_nxt = err_nxt;
    if (q_item.end_mark) begin
      state_nxt = start_st;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      require_r   <= 1'b1;
      state_r     <= htplp_pkg::ST_START_REQ;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        require_r <= cfg_wr_data;
        state_r   <= cfg_wr_data ? htplp_pkg::ST_START_REQ : htplp_pkg::ST_START_OPT;
        err_r     <= 1'b0;
      end else if (q_pop) begin
        state_r <= state_nxt;
        err_r   <= err_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      code_r <= code_nxt;
      byte_r <= byte_nxt;
      rej_r  <= rej_nxt;
      acc_r  <= acc_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign event_code = code_r;
  assign event_byte = byte_r;
  assign rejected   = rej_r;
  assign accepted   = acc_r;

endmodule
